### hw/rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and codes for the sorted insertion table.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int VALUE_W = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  typedef logic signed [VALUE_W-1:0] value_t;

  // control broadcast from the row to every cell
  typedef struct packed {
    logic   ins;
    logic   desc;
    value_t value;
  } cell_ctrl_t;

endpackage

### hw/rtl/sit_if.sv
// ----------------------------------------------------------------------------
// sit_if
// Request and result channels of the sorted insertion table.
// ----------------------------------------------------------------------------
interface sit_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic signed [31:0]           value;
  logic [sit_pkg::INDEX_W-1:0]  index;

  modport source (output valid, kind, value, index, input ready);
  modport sink   (input valid, kind, value, index, output ready);
endinterface

interface sit_res_if;
  logic                         valid;
  logic                         ready;
  logic signed [31:0]           read_value;
  logic                         read_valid;
  logic                         dropped;
  logic [sit_pkg::COUNT_W-1:0]  count;

  modport source (output valid, read_value, read_valid, dropped, count, input ready);
  modport sink   (input valid, read_value, read_valid, dropped, count, output ready);
endinterface

### hw/rtl/sit_cell.sv
// ----------------------------------------------------------------------------
// sit_cell
// One table slot: compares its entry with the new value, keeps it, takes
// the new value or takes its left neighbour's entry.
// ----------------------------------------------------------------------------
module sit_cell (
  input  logic                clk,
  input  sit_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  logic                prefix_in,
  input  sit_pkg::value_t     left_entry,
  output logic                prefix_out,
  output sit_pkg::value_t     entry_r
);

  sit_pkg::value_t entry_nxt;
  logic            ahead;

  // stored entry orders strictly ahead of the new value
  assign ahead = occ && (ctrl.desc ? (entry_r > ctrl.value) : (entry_r < ctrl.value));
  assign prefix_out = prefix_in && ahead;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (!prefix_in) begin
        entry_nxt = left_entry;
      end else if (!ahead) begin
        entry_nxt = ctrl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

### hw/rtl/sit_row.sv
// ----------------------------------------------------------------------------
// sit_row
// Chain of table cells with the position search rippling down the row and
// the read select over the first slots.
// ----------------------------------------------------------------------------
module sit_row #(
  parameter int DEPTH = 16,
  parameter int CW    = 5
) (
  input  logic                         clk,
  input  sit_pkg::cell_ctrl_t          ctrl,
  input  logic [CW-1:0]                count,
  input  logic [sit_pkg::INDEX_W-1:0]  rd_index,
  output sit_pkg::value_t              rd_data
);

  localparam int ReadN = (DEPTH < (1 << sit_pkg::INDEX_W)) ? DEPTH : (1 << sit_pkg::INDEX_W);

  logic            prefix [DEPTH+1];
  sit_pkg::value_t entry  [DEPTH];

  assign prefix[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sit_pkg::value_t left;
    logic            occ;

    if (i == 0) begin : g_first
      assign left = ctrl.value;
    end else begin : g_rest
      assign left = entry[i-1];
    end

    assign occ = CW'(i) < count;

    sit_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ),
      .prefix_in  (prefix[i]),
      .left_entry (left),
      .prefix_out (prefix[i+1]),
      .entry_r    (entry[i])
    );
  end

  // and-or select, slots past the index range are never read
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < ReadN; i++) begin
      if (rd_index == sit_pkg::INDEX_W'(i)) begin
        rd_data = rd_data | entry[i];
      end
    end
  end

endmodule

### hw/rtl/sorted_insertion_table_top.sv
// ----------------------------------------------------------------------------
// sorted_insertion_table_top
// Sorted table of signed values held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : request channel (kind, value, index); insert, read or clear.
//   out_res : one result per request (read_value, read_valid, dropped, count).
//   cfg_we / cfg_wdata : sets the descending bit; write only while idle.
// Every cell compares its entry with the new value at once and the
// insert position ripples down the row, so an insert, read or clear is
// done in the cycle it is accepted. The result sits in the output
// register the next cycle; one request per cycle while results are taken.
// A new request is taken whenever the output register is empty or is
// being emptied in the same cycle; while the receiver stalls with a
// result pending, in_req.ready stays low.
// Reset clears the count and the direction (ascending); entry contents
// are left as they are and are never returned before being written.
// A changed direction keeps the stored order; later inserts search with it.
// ----------------------------------------------------------------------------
module sorted_insertion_table_top #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  sit_req_if.sink      in_req,
  sit_res_if.source    out_res,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  localparam int CW     = $clog2(DEPTH + 1);
  localparam int CountW = sit_pkg::COUNT_W;
  localparam int CmpW   = (CW > sit_pkg::INDEX_W) ? CW : sit_pkg::INDEX_W;

  logic                desc_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  sit_pkg::value_t     rd_value_r;
  logic                rd_valid_r;
  logic                dropped_r;
  logic [CountW-1:0]   out_count_r;

  logic                in_ready;
  logic                accept;
  logic                full;
  logic                rd_hit;
  sit_pkg::cell_ctrl_t ctrl;
  sit_pkg::value_t     rd_data;

  assign in_ready = !out_valid_r || out_res.ready;
  assign accept   = in_req.valid && in_ready;
  assign full     = count_r == CW'(DEPTH);
  assign rd_hit   = (in_req.kind == sit_pkg::KIND_READ) &&
                    (CmpW'(in_req.index) < CmpW'(count_r));

  assign ctrl.ins   = accept && (in_req.kind == sit_pkg::KIND_INSERT) && !full;
  assign ctrl.desc  = desc_r;
  assign ctrl.value = in_req.value;

  sit_row #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_row (
    .clk      (clk),
    .ctrl     (ctrl),
    .count    (count_r),
    .rd_index (in_req.index),
    .rd_data  (rd_data)
  );

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      case (in_req.kind)
        sit_pkg::KIND_INSERT: begin
          if (!full) begin
            count_nxt = count_r + CW'(1);
          end
        end
        sit_pkg::KIND_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_value_r  <= rd_hit ? rd_data : '0;
      rd_valid_r  <= rd_hit;
      dropped_r   <= (in_req.kind == sit_pkg::KIND_INSERT) && full;
      out_count_r <= CountW'(count_nxt);
    end
  end

  assign in_req.ready       = in_ready;
  assign out_res.valid      = out_valid_r;
  assign out_res.read_value = rd_value_r;
  assign out_res.read_valid = rd_valid_r;
  assign out_res.dropped    = dropped_r;
  assign out_res.count      = out_count_r;

endmodule

### verif/tb_sorted_insertion_table_top.sv
// ----------------------------------------------------------------------------
// tb_sorted_insertion_table_top
// Self-checking bench for the sorted insertion table. A scoreboard keeps its
// own sorted copy of the table and predicts one result per request. Directed
// corner requests come first, then random insert/read/clear sessions under
// both directions, with random stalls on the request and result channels.
// ----------------------------------------------------------------------------
module tb_sorted_insertion_table_top;

  typedef sit_pkg::value_t value_t;

  localparam int INDEX_W = sit_pkg::INDEX_W;
  localparam int COUNT_W = sit_pkg::COUNT_W;
  localparam logic [1:0] KIND_INSERT = sit_pkg::KIND_INSERT;
  localparam logic [1:0] KIND_READ   = sit_pkg::KIND_READ;
  localparam logic [1:0] KIND_CLEAR  = sit_pkg::KIND_CLEAR;

  localparam int TABLE_DEPTH = 16;
  localparam int PHASE_REQS  = 350;
  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    value_t             read_value;
    logic               read_valid;
    logic               dropped;
    logic [COUNT_W-1:0] count;
  } table_result_t;

  class table_scoreboard;
    value_t          slots [TABLE_DEPTH];
    int unsigned     fill = 0;
    bit              desc = 0;
    table_result_t   awaited [$];
    int unsigned     errors = 0;
    int unsigned     n_inserts = 0, n_drops = 0, n_hits = 0, n_clears = 0;
    int unsigned     n_checked = 0, n_dir_writes = 0;

    function void set_direction(bit d);
      desc = d;
      n_dir_writes++;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // work out the result of one accepted request and update the copy
    function void note_request(logic [1:0] kind, value_t value,
                               logic [INDEX_W-1:0] index);
      table_result_t r;
      int unsigned   pos;
      int unsigned   i;
      r = '0;
      case (kind)
        KIND_INSERT: begin
          if (fill >= TABLE_DEPTH) begin
            r.dropped = 1'b1;
            n_drops++;
          end else begin
            pos = 0;
            // new value goes ahead of equal entries
            while (pos < fill && (desc ? (slots[pos] > value) : (slots[pos] < value)))
              pos++;
            for (i = fill; i > pos; i--)
              slots[i] = slots[i-1];
            slots[pos] = value;
            fill++;
            n_inserts++;
          end
        end
        KIND_READ: begin
          if (index < fill) begin
            r.read_value = slots[index];
            r.read_valid = 1'b1;
            n_hits++;
          end
        end
        KIND_CLEAR: begin
          fill = 0;
          n_clears++;
        end
        default: ;
      endcase
      r.count = COUNT_W'(fill);
      awaited.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (awaited.size() == 0) begin
        $error("result with no request outstanding (count %0d)", got.count);
        errors++;
        return;
      end
      want = awaited.pop_front();
      n_checked++;
      if (got.read_value !== want.read_value) begin
        $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
        errors++;
      end
      if (got.read_valid !== want.read_valid) begin
        $error("read_valid: expected %0b, got %0b", want.read_valid, got.read_valid);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  bit   no_gaps = 0;
  int unsigned n_sent = 0;

  table_scoreboard sb;

  sit_req_if req_bus ();
  sit_res_if res_bus ();

  sorted_insertion_table_top #(
    .DEPTH (TABLE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_bus.sink),
    .out_res   (res_bus.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return value_t'($signed($urandom_range(8)) - 4);  // lots of equals
      default: return value_t'($urandom);
    endcase
  endfunction

  // present one request and hold it until taken; valid stays high for the next unless a random gap follows
  task automatic send_request(input logic [1:0] kind, input value_t value,
                              input logic [INDEX_W-1:0] index);
    req_bus.valid <= 1'b1;
    req_bus.kind  <= kind;
    req_bus.value <= value;
    req_bus.index <= index;
    do @(posedge clk); while (!req_bus.ready);
    sb.note_request(kind, value, index);
    n_sent++;
    if (!no_gaps && $urandom_range(99) < 7) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // hold off until every result is back
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_direction(input bit d);
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    sb.set_direction(d);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly fill-then-read sessions, some noise
  task automatic run_session();
    int unsigned n;
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 6))
        send_request(2'($urandom_range(3)), value_t'($urandom), INDEX_W'($urandom));
    end else begin
      if ($urandom_range(2) == 0)
        send_request(KIND_CLEAR, value_t'($urandom), INDEX_W'($urandom));
      n = $urandom_range(1, 20);
      repeat (n) begin
        if ($urandom_range(5) == 0)
          send_request(KIND_READ, value_t'($urandom), INDEX_W'($urandom));
        else
          send_request(KIND_INSERT, pick_value(), INDEX_W'($urandom));
      end
      n = $urandom_range(1, 18);
      repeat (n)
        send_request(KIND_READ, value_t'($urandom), INDEX_W'($urandom));
    end
  endtask

  // result side: random stalls, check every accepted result
  initial begin
    table_result_t got;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_bus.valid && res_bus.ready) begin
        got.read_value = res_bus.read_value;
        got.read_valid = res_bus.read_valid;
        got.dropped    = res_bus.dropped;
        got.count      = res_bus.count;
        sb.check_result(got);
      end
      res_bus.ready <= no_gaps || ($urandom_range(99) >= 7);
    end
  end

  initial begin
    bit          dirs [5];
    int unsigned target;
    dirs = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    sb = new();
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= 1'b0;
    req_bus.valid <= 1'b0;
    req_bus.kind  <= KIND_INSERT;
    req_bus.value <= '0;
    req_bus.index <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, ascending after reset
    send_request(KIND_READ,   32'sd0, 4'd0);    // empty table
    send_request(KIND_NOP,    32'sd5, 4'd3);
    send_request(KIND_INSERT, 32'sh7FFF_FFFF, 4'd0);
    send_request(KIND_INSERT, 32'sh8000_0000, 4'd0);
    send_request(KIND_INSERT, 32'sd0, 4'd0);
    send_request(KIND_INSERT, 32'sd0, 4'd0);
    send_request(KIND_INSERT, -32'sd1, 4'd0);
    send_request(KIND_READ,   32'sd0, 4'd0);
    send_request(KIND_READ,   32'sd0, 4'd4);
    send_request(KIND_READ,   32'sd0, 4'd5);    // just past the count
    repeat (11) send_request(KIND_INSERT, pick_value(), 4'd0);
    send_request(KIND_INSERT, 32'sd7, 4'd0);    // full, dropped
    send_request(KIND_READ,   32'sd0, 4'd15);
    send_request(KIND_CLEAR,  32'sd0, 4'd0);
    send_request(KIND_READ,   32'sd0, 4'd0);

    foreach (dirs[p]) begin
      drain();
      write_direction(dirs[p]);
      no_gaps = (p == 2);
      target  = n_sent + PHASE_REQS;
      while (n_sent < target - PHASE_REQS / 2) run_session();
      drain();
      while (n_sent < target) run_session();
    end
    no_gaps = 0;

    drain();
    repeat (4) @(posedge clk);
    $display("%0d requests: %0d stored, %0d dropped when full, %0d in-range reads, %0d clears",
             n_sent, sb.n_inserts, sb.n_drops, sb.n_hits, sb.n_clears);
    $display("%0d results checked across %0d direction writes",
             sb.n_checked, sb.n_dir_writes);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
